/* sv/matrix_inverse_4x4_unit_defines.svh */
// Assertion macros shared by the matrix inverse block.
`ifndef MATRIX_INVERSE_4X4_UNIT_DEFINES_SVH
`define MATRIX_INVERSE_4X4_UNIT_DEFINES_SVH

// Check a property on the block clock, held off while reset is low.
`define MINV4_CHECK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on the block clock that must also hold through reset.
`define MINV4_CHECK_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/minv4_pkg.sv */
`default_nettype none

package minv4_pkg;

    localparam int unsigned IN_ELEM_W  = 12;
    localparam int unsigned IN_TDATA_W = 4 * IN_ELEM_W;
    localparam int unsigned ROW_W      = 2;
    localparam int unsigned INV_W      = 32;
    localparam int unsigned DET_OUT_W  = 51;
    localparam int unsigned OUT_USED_W = ROW_W + 4 * INV_W + DET_OUT_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_CHECK,
        ST_DLOAD,
        ST_DRUN,
        ST_EMIT
    } state_t;

    // Steps of one cofactor term a * (b*c - d*e), plus the determinant step.
    typedef enum logic [2:0] {
        PH_ROW1U,
        PH_ROW2V,
        PH_ROW1V,
        PH_ROW2U,
        PH_LEAD,
        PH_ACC,
        PH_DET
    } phase_t;

endpackage

`default_nettype wire

/* sv/matrix_inverse_4x4_unit.sv */
// 4x4 fixed-point matrix inverse by adjugate over determinant.
// Input channel s_*: one matrix row per transfer, four signed elements in
// s_tdata. Rows one to three are stored only; the fourth row starts the work.
// Output channel m_*: one row of the inverse per transfer, rows 0..3 in
// order, tlast on row 3. A zero determinant gives a single transfer with
// tuser (singular) and tlast set and all data zero.
// After the fourth row the block computes 16 cofactors with 4 determinant
// steps folded in, checks the determinant for zero, then forms 16 quotients
// one at a time in one radix-2 restoring divider, loading an output row once
// its four quotients are done. The single shared multiplier and the
// bit-serial divider set the pace. s_tready is low while a matrix is in work
// and high again once the last result sits in the output register.
// Reset (aresetn low, synchronous) drops any partial matrix and any pending
// result. A stalled receiver holds the output register; the block waits
// before overwriting it and does not lose or repeat a row.
`default_nettype none

`include "matrix_inverse_4x4_unit_defines.svh"

module matrix_inverse_4x4_unit
    import minv4_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 6,
    parameter int unsigned ELEM_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // elem_col0, elem_col1, elem_col2, elem_col3 (12 bits each)
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_row (2), inv_col0..inv_col3 (32 each), det_value (51), zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // singular
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int unsigned EB     = ELEM_BITS;
    localparam int unsigned MIN_W  = 2 * EB + 1;
    localparam int unsigned COF_W  = 3 * EB + 1;
    localparam int unsigned PROD_W = EB + COF_W;
    localparam int unsigned DET_W  = 4 * EB + 2;
    localparam int unsigned NUM_W  = COF_W + 2 * FRAC_BITS;
    localparam int unsigned CNT_W  = $clog2(NUM_W);
    localparam int unsigned PAD_W  = OUT_TDATA_W - OUT_USED_W;

    // Control state
    state_t              state_reg, state_next;
    phase_t              ph_reg, ph_next;
    logic [1:0]          rows_reg, rows_next;
    logic [3:0]          idx_reg, idx_next;
    logic [1:0]          term_reg, term_next;
    logic [1:0]          col_reg, col_next;
    logic [1:0]          orow_reg, orow_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;

    // Datapath state
    logic signed [EB-1:0]     x_reg, x_next;
    logic signed [MIN_W-1:0]  minor_reg, minor_next;
    logic signed [COF_W-1:0]  acc_reg, acc_next;
    logic signed [DET_W-1:0]  det_reg, det_next;
    logic [DET_W-1:0]         den_reg, den_next;
    logic [DET_W-1:0]         rem_reg, rem_next;
    logic [NUM_W-1:0]         q_reg, q_next;
    logic                     neg_reg, neg_next;
    logic [INV_W-1:0]         inv_reg [4];
    logic [INV_W-1:0]         inv_val;
    logic                     inv_we;

    // Output register payload
    logic [ROW_W-1:0]         o_row_reg, o_row_next;
    logic [INV_W-1:0]         o_inv_reg [4];
    logic [INV_W-1:0]         o_inv_next [4];
    logic [DET_OUT_W-1:0]     o_det_reg, o_det_next;
    logic                     o_sing_reg, o_sing_next;
    logic                     o_last_reg, o_last_next;
    logic                     o_load;

    // Row memory and cofactor store
    logic [4*EB-1:0]          mat_mem [4];
    logic [4*EB-1:0]          mem_row_reg;
    logic [1:0]               mem_col_reg;
    logic [1:0]               rd_row, rd_col;
    logic signed [EB-1:0]     rd_elem;
    logic signed [COF_W-1:0]  cof_arr [16];
    logic [3:0]               cof_addr;
    logic signed [COF_W-1:0]  cof_rd;
    logic signed [COF_W-1:0]  cof_fin;
    logic                     cof_we;

    // Shared multiplier
    logic signed [EB-1:0]     mul_a;
    logic signed [COF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // Cofactor index decode
    logic [1:0] r_sel, c_sel;
    logic [1:0] rs0, rs1, rs2, cs0, cs1, cs2, cu, cv, ck;

    // Divider helpers
    logic [DET_W:0]           rem_sh;
    logic                     quo_bit;
    logic signed [NUM_W-1:0]  num_s;
    logic                     in_xfer, out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign rd_elem = mem_row_reg[mem_col_reg*EB +: EB];
    assign cof_addr = (state_reg == ST_COF) ? idx_reg : {col_reg, orow_reg};
    assign cof_rd = cof_arr[cof_addr];
    assign mul_a = rd_elem;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Rows and columns left after striking row r and column c
    always_comb begin
        r_sel = idx_reg[3:2];
        c_sel = idx_reg[1:0];
        rs0 = (r_sel == 2'd0) ? 2'd1 : 2'd0;
        rs1 = (r_sel <= 2'd1) ? 2'd2 : 2'd1;
        rs2 = (r_sel <= 2'd2) ? 2'd3 : 2'd2;
        cs0 = (c_sel == 2'd0) ? 2'd1 : 2'd0;
        cs1 = (c_sel <= 2'd1) ? 2'd2 : 2'd1;
        cs2 = (c_sel <= 2'd2) ? 2'd3 : 2'd2;
        case (term_reg)
            2'd0: begin
                ck = cs0; cu = cs1; cv = cs2;
            end
            2'd1: begin
                ck = cs1; cu = cs0; cv = cs2;
            end
            default: begin
                ck = cs2; cu = cs0; cv = cs1;
            end
        endcase
    end

    // Read address and multiplier operand per step
    always_comb begin
        rd_row = rs1;
        rd_col = cu;
        mul_b  = COF_W'(x_reg);
        unique case (ph_reg)
            PH_ROW1U: begin
                rd_row = rs1; rd_col = cu;
            end
            PH_ROW2V: begin
                rd_row = rs2; rd_col = cv;
            end
            PH_ROW1V: begin
                rd_row = rs1; rd_col = cv;
            end
            PH_ROW2U: begin
                rd_row = rs2; rd_col = cu;
            end
            PH_LEAD: begin
                rd_row = rs0; rd_col = ck;
            end
            PH_ACC: begin
                rd_row = 2'd0; rd_col = c_sel;
                mul_b  = COF_W'(minor_reg);
            end
            PH_DET: begin
                rd_row = 2'd0; rd_col = c_sel;
                mul_b  = cof_rd;
            end
            default: begin
                rd_row = rs1; rd_col = cu;
            end
        endcase
    end

    // Divider step and saturation of the finished quotient
    always_comb begin
        rem_sh  = {rem_reg, q_reg[NUM_W-1]};
        quo_bit = (rem_sh >= {1'b0, den_reg});
        num_s   = NUM_W'(cof_rd) <<< (2 * FRAC_BITS);
        q_next  = {q_reg[NUM_W-2:0], quo_bit};
        if (!neg_reg) begin
            inv_val = (q_next > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_next[INV_W-1:0];
        end else begin
            inv_val = (q_next > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                          : INV_W'(-q_next);
        end
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        rows_next    = rows_reg;
        idx_next     = idx_reg;
        term_next    = term_reg;
        col_next     = col_reg;
        orow_next    = orow_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        x_next       = x_reg;
        minor_next   = minor_reg;
        acc_next     = acc_reg;
        det_next     = det_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        cof_fin      = acc_reg;
        cof_we       = 1'b0;
        inv_we       = 1'b0;
        o_load       = 1'b0;
        o_row_next   = orow_reg;
        o_det_next   = DET_OUT_W'(det_reg);
        o_sing_next  = 1'b0;
        o_last_next  = (orow_reg == 2'd3);
        for (int i = 0; i < 4; i++) begin
            o_inv_next[i] = inv_reg[i];
        end

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    rows_next = rows_reg + 2'd1;
                    if (rows_reg == 2'd3) begin
                        state_next = ST_COF;
                        ph_next    = PH_ROW1U;
                        idx_next   = '0;
                        term_next  = '0;
                        acc_next   = '0;
                        det_next   = '0;
                    end
                end
            end
            ST_COF: begin
                unique case (ph_reg)
                    PH_ROW1U: ph_next = PH_ROW2V;
                    PH_ROW2V: begin
                        x_next  = rd_elem;
                        ph_next = PH_ROW1V;
                    end
                    PH_ROW1V: begin
                        minor_next = MIN_W'(mul_p);
                        ph_next    = PH_ROW2U;
                    end
                    PH_ROW2U: begin
                        x_next  = rd_elem;
                        ph_next = PH_LEAD;
                    end
                    PH_LEAD: begin
                        minor_next = minor_reg - MIN_W'(mul_p);
                        ph_next    = PH_ACC;
                    end
                    PH_ACC: begin
                        acc_next = (term_reg == 2'd1) ? acc_reg - COF_W'(mul_p)
                                                      : acc_reg + COF_W'(mul_p);
                        if (term_reg != 2'd2) begin
                            term_next = term_reg + 2'd1;
                            ph_next   = PH_ROW1U;
                        end else begin
                            cof_fin = (r_sel[0] ^ c_sel[0]) ? -acc_next : acc_next;
                            cof_we  = 1'b1;
                            if (r_sel == 2'd0) begin
                                ph_next = PH_DET;
                            end else begin
                                acc_next  = '0;
                                term_next = '0;
                                ph_next   = PH_ROW1U;
                                idx_next  = idx_reg + 4'd1;
                                if (idx_reg == 4'd15) begin
                                    state_next = ST_CHECK;
                                end
                            end
                        end
                    end
                    PH_DET: begin
                        det_next  = det_reg + DET_W'(mul_p);
                        acc_next  = '0;
                        term_next = '0;
                        ph_next   = PH_ROW1U;
                        idx_next  = idx_reg + 4'd1;
                    end
                    default: ph_next = PH_ROW1U;
                endcase
            end
            ST_CHECK: begin
                den_next  = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
                orow_next = '0;
                col_next  = '0;
                if (det_reg != '0) begin
                    state_next = ST_DLOAD;
                end else if (out_free) begin
                    o_load       = 1'b1;
                    o_row_next   = '0;
                    o_det_next   = '0;
                    o_sing_next  = 1'b1;
                    o_last_next  = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        o_inv_next[i] = '0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DLOAD: begin
                neg_next   = cof_rd[COF_W-1] ^ det_reg[DET_W-1];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DRUN;
            end
            ST_DRUN: begin
                rem_next = quo_bit ? DET_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DET_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    inv_we = 1'b1;
                    col_next = col_reg + 2'd1;
                    state_next = (col_reg == 2'd3) ? ST_EMIT : ST_DLOAD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_load       = 1'b1;
                    m_valid_next = 1'b1;
                    orow_next    = orow_reg + 2'd1;
                    col_next     = '0;
                    state_next   = (orow_reg == 2'd3) ? ST_IDLE : ST_DLOAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ph_reg      <= PH_ROW1U;
            rows_reg    <= '0;
            idx_reg     <= '0;
            term_reg    <= '0;
            col_reg     <= '0;
            orow_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            rows_reg    <= rows_next;
            idx_reg     <= idx_next;
            term_reg    <= term_next;
            col_reg     <= col_next;
            orow_reg    <= orow_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers, row memory and cofactor store
    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        minor_reg   <= minor_next;
        acc_reg     <= acc_next;
        det_reg     <= det_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        mem_row_reg <= mat_mem[rd_row];
        mem_col_reg <= rd_col;
        if (state_reg == ST_DLOAD) begin
            q_reg <= num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
        end else if (state_reg == ST_DRUN) begin
            q_reg <= q_next;
        end
        if (in_xfer) begin
            for (int j = 0; j < 4; j++) begin
                mat_mem[rows_reg][j*EB +: EB] <= s_tdata[j*IN_ELEM_W +: EB];
            end
        end
        if (cof_we) begin
            cof_arr[idx_reg] <= cof_fin;
        end
        if (inv_we) begin
            inv_reg[col_reg] <= inv_val;
        end
        if (o_load) begin
            o_row_reg  <= o_row_next;
            o_det_reg  <= o_det_next;
            o_sing_reg <= o_sing_next;
            o_last_reg <= o_last_next;
            for (int i = 0; i < 4; i++) begin
                o_inv_reg[i] <= o_inv_next[i];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, o_det_reg, o_inv_reg[3], o_inv_reg[2],
                       o_inv_reg[1], o_inv_reg[0], o_row_reg};
    assign m_tuser  = o_sing_reg;
    assign m_tlast  = o_last_reg;

    // A singular result is always the only, and so the last, row of its matrix
    `MINV4_CHECK(a_sing_last, m_tvalid && m_tuser |-> m_tlast, "singular without last")
    // A complete non-singular result run ends on row 3
    `MINV4_CHECK(a_last_row3, m_tvalid && m_tlast && !m_tuser |-> m_tdata[1:0] == 2'd3,
        "last on wrong row")
    // The fourth row starts the cofactor pass
    `MINV4_CHECK(a_start_cof, in_xfer && rows_reg == 2'd3 |=> state_reg == ST_COF,
        "fourth row did not start work")
    // No input is taken while a matrix is in work
    `MINV4_CHECK_ALWAYS(a_busy_stall, state_reg != ST_IDLE |-> !s_tready,
        "ready while busy")

endmodule

`default_nettype wire
